FILE: design/tick_driven_timer_bank_defines.svh
// Assertion helpers shared by the timer bank RTL.
// Both expect signals named clk and rst_n in the calling scope.
`ifndef TICK_DRIVEN_TIMER_BANK_DEFINES_SVH
`define TICK_DRIVEN_TIMER_BANK_DEFINES_SVH

// Same-cycle implication.
`define TDTB_ASSERT_IMPL(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("timer bank check failed");

// Next-cycle implication.
`define TDTB_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("timer bank check failed");

`endif

FILE: design/tdtb_pkg.sv
`timescale 1ns / 1ps

package tdtb_pkg;

    localparam int NUM_TIMERS = 16;
    localparam int TICK_BITS  = 48;
    localparam int MAX_RES    = 16;

    localparam int SLOT_IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int REP_CNT_W  = $clog2(MAX_RES + 1);

    localparam int ACT_W      = 3;
    localparam int SLOT_W     = 4;
    localparam int IVAL_W     = 32;
    localparam int COUNT_W    = 32;
    localparam int RES_W      = 2;

    // slot, periodic, interval
    localparam int IN_FIELDS_W = SLOT_W + 1 + IVAL_W;
    localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    // timer_slot, times_fired
    localparam int OUT_FIELDS_W = SLOT_W + COUNT_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

    localparam logic [ACT_W-1:0] ACT_TICK    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_CREATE  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_START   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_STOP    = 3'd3;
    localparam logic [ACT_W-1:0] ACT_DESTROY = 3'd4;

    localparam logic [RES_W-1:0] RES_FIRED   = 2'd0;
    localparam logic [RES_W-1:0] RES_DONE    = 2'd1;
    localparam logic [RES_W-1:0] RES_EXISTS  = 2'd2;
    localparam logic [RES_W-1:0] RES_NOTIMER = 2'd3;

    typedef logic [SLOT_IDX_W-1:0] slot_idx_t;

    typedef struct packed {
        logic [COUNT_W-1:0]   fire_count;
        logic [TICK_BITS-1:0] deadline;
        logic [IVAL_W-1:0]    interval;
    } timer_entry_t;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_WALK  = 4'b0010,
        S_FLUSH = 4'b0100,
        S_CMD   = 4'b1000
    } state_t;

    function automatic slot_idx_t slot_index(input logic [SLOT_W-1:0] slot);
        return SLOT_IDX_W'(slot);
    endfunction

endpackage

FILE: design/tick_driven_timer_bank.sv
`timescale 1ns / 1ps
`include "tick_driven_timer_bank_defines.svh"

// Bank of NUM_TIMERS one-shot or periodic timer slots driven by tick and command
// transfers on the input stream; tuser carries the action. A tick walks every slot
// through the slot memory's registered read port, one slot per cycle unless a fired
// result stalls on a busy output, and holds off the input until the walk and flush end.
// Create, start, stop and destroy hold the input off until their result is registered.
// Each tick sends one fired result per firing slot, in slot order and at most
// MAX_RES, tlast on the final one, and nothing if no slot fires; every command sends
// exactly one result with tlast set. No clearing pass is needed after reset.
module tick_driven_timer_bank (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [tdtb_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // slot, periodic, interval
    input  logic [tdtb_pkg::ACT_W-1:0]       s_axis_tuser,  // action
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [tdtb_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // timer_slot, times_fired
    output logic [tdtb_pkg::RES_W-1:0]       m_axis_tuser,  // event_res
    output logic                             m_axis_tlast
);
    import tdtb_pkg::*;

    state_t state_reg, state_next;

    logic [SLOT_W-1:0]    in_slot;
    logic                 in_periodic;
    logic [IVAL_W-1:0]    in_interval;

    logic [ACT_W-1:0]     act_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic                 per_reg;
    logic [IVAL_W-1:0]    ival_reg;

    logic [TICK_BITS-1:0] tick_count_reg, tick_count_next;
    logic [TICK_BITS-1:0] old_tick_reg, old_tick_next;
    logic [NUM_TIMERS-1:0] occupied_reg, occupied_next;
    logic [NUM_TIMERS-1:0] enabled_reg, enabled_next;
    logic [NUM_TIMERS-1:0] periodic_reg, periodic_next;
    slot_idx_t            walk_idx_reg, walk_idx_next;
    logic [REP_CNT_W-1:0] rep_cnt_reg, rep_cnt_next;

    logic                 pend_valid_reg, pend_valid_next;
    logic [SLOT_W-1:0]    pend_slot_reg, pend_slot_next;
    logic [COUNT_W-1:0]   pend_cnt_reg, pend_cnt_next;

    logic                 out_valid_reg, out_valid_next;
    logic [RES_W-1:0]     out_res_reg, out_res_next;
    logic [SLOT_W-1:0]    out_slot_reg, out_slot_next;
    logic [COUNT_W-1:0]   out_cnt_reg, out_cnt_next;
    logic                 out_last_reg, out_last_next;

    timer_entry_t         mem [NUM_TIMERS];
    timer_entry_t         rd_data_reg;
    logic                 rd_en;
    slot_idx_t            rd_addr;
    logic                 mem_we;
    slot_idx_t            mem_waddr;
    timer_entry_t         mem_wdata;

    logic                 in_xfer;
    logic                 out_free;
    slot_idx_t            cur_idx;
    logic                 fire;
    logic                 capture;
    logic                 stall;
    logic [COUNT_W-1:0]   new_cnt;
    logic [TICK_BITS-1:0] new_deadline;
    slot_idx_t            cmd_idx;
    logic                 slot_ok;
    logic                 busy;

    assign in_slot     = s_axis_tdata[SLOT_W-1:0];
    assign in_periodic = s_axis_tdata[SLOT_W];
    assign in_interval = s_axis_tdata[SLOT_W+IVAL_W:SLOT_W+1];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_cnt_reg, out_slot_reg};
    assign m_axis_tuser  = out_res_reg;
    assign m_axis_tlast  = out_last_reg;

    // walk evaluation: rd_data_reg holds the entry of cur_idx
    assign cur_idx      = walk_idx_reg;
    assign fire         = occupied_reg[cur_idx] && enabled_reg[cur_idx]
                          && (rd_data_reg.deadline <= old_tick_reg);
    assign capture      = fire && (rep_cnt_reg < REP_CNT_W'(MAX_RES));
    // a new firing would push the pending one out, which needs a free output
    assign stall        = capture && pend_valid_reg && !out_free;
    assign new_cnt      = rd_data_reg.fire_count + COUNT_W'(1);
    assign new_deadline = old_tick_reg + TICK_BITS'(rd_data_reg.interval);

    assign cmd_idx = slot_index(slot_reg);
    assign slot_ok = (int'(slot_reg) < NUM_TIMERS);
    assign busy    = slot_ok && occupied_reg[cmd_idx];

    always_comb
    begin
        state_next      = state_reg;
        tick_count_next = tick_count_reg;
        old_tick_next   = old_tick_reg;
        occupied_next   = occupied_reg;
        enabled_next    = enabled_reg;
        periodic_next   = periodic_reg;
        walk_idx_next   = walk_idx_reg;
        rep_cnt_next    = rep_cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        pend_cnt_next   = pend_cnt_reg;
        out_valid_next  = out_valid_reg;
        out_res_next    = out_res_reg;
        out_slot_next   = out_slot_reg;
        out_cnt_next    = out_cnt_reg;
        out_last_next   = out_last_reg;
        rd_en           = 1'b0;
        rd_addr         = walk_idx_reg;
        mem_we          = 1'b0;
        mem_waddr       = cur_idx;
        mem_wdata       = rd_data_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    rd_en = 1'b1;
                    if (s_axis_tuser == ACT_TICK)
                    begin
                        old_tick_next   = tick_count_reg;
                        tick_count_next = tick_count_reg + TICK_BITS'(1);
                        walk_idx_next   = '0;
                        rd_addr         = '0;
                        rep_cnt_next    = '0;
                        state_next      = S_WALK;
                    end
                    else
                    begin
                        rd_addr    = slot_index(in_slot);
                        state_next = S_CMD;
                    end
                end
            end

            S_WALK:
            begin
                if (!stall)
                begin
                    if (fire)
                    begin
                        mem_we               = 1'b1;
                        mem_wdata.fire_count = new_cnt;
                        if (periodic_reg[cur_idx])
                        begin
                            mem_wdata.deadline = new_deadline;
                        end
                        else
                        begin
                            enabled_next[cur_idx] = 1'b0;
                        end
                    end
                    if (capture)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_res_next   = RES_FIRED;
                            out_slot_next  = pend_slot_reg;
                            out_cnt_next   = pend_cnt_reg;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_slot_next  = SLOT_W'(cur_idx);
                        pend_cnt_next   = new_cnt;
                        rep_cnt_next    = rep_cnt_reg + REP_CNT_W'(1);
                    end
                    if (cur_idx == SLOT_IDX_W'(NUM_TIMERS - 1))
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        walk_idx_next = SLOT_IDX_W'(cur_idx + 1'b1);
                        rd_en         = 1'b1;
                        rd_addr       = SLOT_IDX_W'(cur_idx + 1'b1);
                    end
                end
            end

            S_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_res_next    = RES_FIRED;
                    out_slot_next   = pend_slot_reg;
                    out_cnt_next    = pend_cnt_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            S_CMD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_res_next   = RES_NOTIMER;
                    out_slot_next  = slot_reg;
                    out_cnt_next   = '0;
                    out_last_next  = 1'b1;
                    state_next     = S_IDLE;
                    case (act_reg) inside
                        ACT_CREATE:
                        begin
                            if (busy)
                            begin
                                out_res_next = RES_EXISTS;
                                out_cnt_next = rd_data_reg.fire_count;
                            end
                            else if (slot_ok)
                            begin
                                occupied_next[cmd_idx] = 1'b1;
                                enabled_next[cmd_idx]  = 1'b0;
                                periodic_next[cmd_idx] = per_reg;
                                mem_we                 = 1'b1;
                                mem_waddr              = cmd_idx;
                                mem_wdata.fire_count   = '0;
                                mem_wdata.deadline     = '0;
                                mem_wdata.interval     = ival_reg;
                                out_res_next           = RES_DONE;
                            end
                        end
                        ACT_START, ACT_STOP, ACT_DESTROY:
                        begin
                            if (busy)
                            begin
                                out_res_next = RES_DONE;
                                out_cnt_next = rd_data_reg.fire_count;
                                if (act_reg == ACT_START)
                                begin
                                    enabled_next[cmd_idx] = 1'b1;
                                end
                                else
                                begin
                                    enabled_next[cmd_idx] = 1'b0;
                                end
                                if (act_reg == ACT_DESTROY)
                                begin
                                    occupied_next[cmd_idx] = 1'b0;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            tick_count_reg <= '0;
            occupied_reg   <= '0;
            enabled_reg    <= '0;
            periodic_reg   <= '0;
            walk_idx_reg   <= '0;
            rep_cnt_reg    <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            tick_count_reg <= tick_count_next;
            occupied_reg   <= occupied_next;
            enabled_reg    <= enabled_next;
            periodic_reg   <= periodic_next;
            walk_idx_reg   <= walk_idx_next;
            rep_cnt_reg    <= rep_cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        old_tick_reg  <= old_tick_next;
        pend_slot_reg <= pend_slot_next;
        pend_cnt_reg  <= pend_cnt_next;
        out_res_reg   <= out_res_next;
        out_slot_reg  <= out_slot_next;
        out_cnt_reg   <= out_cnt_next;
        out_last_reg  <= out_last_next;
        if (in_xfer)
        begin
            act_reg  <= s_axis_tuser;
            slot_reg <= in_slot;
            per_reg  <= in_periodic;
            ival_reg <= in_interval;
        end
    end

    // slot memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    `TDTB_ASSERT_NEXT(a_tick_enters_walk,
        in_xfer && (s_axis_tuser == ACT_TICK), state_reg == S_WALK)
    `TDTB_ASSERT_NEXT(a_tick_count_step,
        in_xfer && (s_axis_tuser == ACT_TICK),
        tick_count_reg == TICK_BITS'($past(tick_count_reg) + TICK_BITS'(1)))
    `TDTB_ASSERT_IMPL(a_no_pending_when_idle, state_reg == S_IDLE, !pend_valid_reg)
    `TDTB_ASSERT_IMPL(a_report_cap, 1'b1, rep_cnt_reg <= REP_CNT_W'(MAX_RES))
    `TDTB_ASSERT_IMPL(a_command_result_last,
        out_valid_reg && (out_res_reg != RES_FIRED), out_last_reg)

endmodule
